/* sv/tbsc_pkg.sv */
// Package for the binary tree shape checker: sizes, item and result
// structs, memory request structs and the sequencer state type. No dependencies.
package tbsc_pkg;

  // Store depth; node indexes and counts are sized from it
  localparam int MAX_NODES   = 1024;
  localparam int NODE_IDX_W  = $clog2(MAX_NODES);
  localparam int NODE_CNT_W  = NODE_IDX_W + 1;
  // Child index width on the input ports
  localparam int FIELD_IDX_W = 10;
  // Width used to range-check a child index against the node count
  localparam int CMP_W = (FIELD_IDX_W > NODE_CNT_W) ? FIELD_IDX_W : NODE_CNT_W;

  typedef logic [NODE_IDX_W-1:0]  node_idx_t;
  typedef logic [NODE_CNT_W-1:0]  node_cnt_t;
  typedef logic [FIELD_IDX_W-1:0] fidx_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  // One input beat
  typedef struct packed {
    logic  left_present;
    fidx_t left_index;
    logic  right_present;
    fidx_t right_index;
    logic  last_node;
  } item_t;

  // One result beat
  typedef struct packed {
    logic strobe;
    logic valid_res;
    logic overflow;
  } res_t;

  // Child table word, one per node
  typedef struct packed {
    logic  lp;
    fidx_t li;
    logic  rp;
    fidx_t ri;
  } tbl_entry_t;

  // Parent count and visited flag, one per node
  typedef struct packed {
    logic       visited;
    logic [1:0] count;
  } cnt_word_t;

  typedef struct packed {
    logic       we;
    node_idx_t  waddr;
    tbl_entry_t wdata;
    logic       re;
    node_idx_t  raddr;
  } tbl_req_t;

  typedef struct packed {
    logic      we;
    node_idx_t waddr;
    cnt_word_t wdata;
    logic      re;
    node_idx_t raddr;
  } cnt_req_t;

  typedef struct packed {
    logic      we;
    node_idx_t waddr;
    node_idx_t wdata;
    logic      re;
    node_idx_t raddr;
  } stk_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAR_RD,
    ST_PAR_L,
    ST_PAR_LWR,
    ST_PAR_R,
    ST_PAR_RWR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_WALK_POP,
    ST_WALK_RD,
    ST_WALK_VIS,
    ST_WALK_PUSH,
    ST_CLR
  } st_t;

  // Child field widened for the range check against the node count
  function automatic cmp_t child_cmp(input fidx_t c);
    return CMP_W'(c);
  endfunction

  // Child field as a store address (only meaningful once range-checked)
  function automatic node_idx_t child_addr(input fidx_t c);
    cmp_t w;
    w = CMP_W'(c);
    return w[NODE_IDX_W-1:0];
  endfunction

endpackage

/* sv/tbsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/tbsc_seq.sv */
// Sequencer of the shape checker: loads nodes, runs the parent count,
// root scan, depth-first walk and clear passes over the stores. Uses tbsc_pkg.
module tbsc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tbsc_pkg::item_t     item,
  output logic                busy,
  output tbsc_pkg::res_t      res,
  output tbsc_pkg::tbl_req_t  tbl_req,
  input  tbsc_pkg::tbl_entry_t tbl_rdata,
  output tbsc_pkg::cnt_req_t  cnt_req,
  input  tbsc_pkg::cnt_word_t cnt_rdata,
  output tbsc_pkg::stk_req_t  stk_req,
  input  tbsc_pkg::node_idx_t stk_rdata
);

  tbsc_pkg::st_t       state_r, state_nxt;
  tbsc_pkg::node_cnt_t idx_r, idx_nxt;
  tbsc_pkg::node_cnt_t node_total_r, node_total_nxt;
  tbsc_pkg::node_cnt_t clr_lim_r, clr_lim_nxt;
  tbsc_pkg::node_cnt_t depth_r, depth_nxt;
  tbsc_pkg::node_cnt_t reached_r, reached_nxt;
  tbsc_pkg::node_idx_t root_r, root_nxt;
  tbsc_pkg::node_idx_t node_r, node_nxt;
  tbsc_pkg::tbl_entry_t entry_r, entry_nxt;
  logic [1:0]          roots_r, roots_nxt;
  logic                bad_seen_r, bad_seen_nxt;
  logic                fail_r, fail_nxt;
  logic                emit_r, emit_nxt;
  tbsc_pkg::res_t      res_r, res_nxt;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tbsc_pkg::ST_CLR;
      idx_r        <= '0;
      node_total_r <= '0;
      clr_lim_r    <= tbsc_pkg::NODE_CNT_W'(tbsc_pkg::MAX_NODES);
      depth_r      <= '0;
      reached_r    <= '0;
      roots_r      <= '0;
      bad_seen_r   <= 1'b0;
      fail_r       <= 1'b0;
      emit_r       <= 1'b0;
      res_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      node_total_r <= node_total_nxt;
      clr_lim_r    <= clr_lim_nxt;
      depth_r      <= depth_nxt;
      reached_r    <= reached_nxt;
      roots_r      <= roots_nxt;
      bad_seen_r   <= bad_seen_nxt;
      fail_r       <= fail_nxt;
      emit_r       <= emit_nxt;
      res_r        <= res_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    root_r  <= root_nxt;
    node_r  <= node_nxt;
    entry_r <= entry_nxt;
  end

  // next state, counters and store requests
  always_comb begin
    tbsc_pkg::node_cnt_t idx_inc;
    tbsc_pkg::cnt_word_t cw;
    logic [1:0]          roots_v;
    tbsc_pkg::node_idx_t root_v;
    logic                full;

    state_nxt      = state_r;
    idx_nxt        = idx_r;
    node_total_nxt = node_total_r;
    clr_lim_nxt    = clr_lim_r;
    depth_nxt      = depth_r;
    reached_nxt    = reached_r;
    root_nxt       = root_r;
    node_nxt       = node_r;
    entry_nxt      = entry_r;
    roots_nxt      = roots_r;
    bad_seen_nxt   = bad_seen_r;
    fail_nxt       = fail_r;
    emit_nxt       = emit_r;
    res_nxt        = res_r;
    res_nxt.strobe = 1'b0;
    tbl_req        = '0;
    cnt_req        = '0;
    stk_req        = '0;

    idx_inc = idx_r + 1'b1;
    full    = (depth_r >= tbsc_pkg::NODE_CNT_W'(tbsc_pkg::MAX_NODES));
    cw      = cnt_rdata;
    roots_v = roots_r;
    root_v  = root_r;

    case (state_r)
      // take node beats; the last one starts the check, or reports overflow if the set did not fit
      tbsc_pkg::ST_IDLE: begin
        if (start) begin
          if (node_total_r < tbsc_pkg::NODE_CNT_W'(tbsc_pkg::MAX_NODES)) begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = node_total_r[tbsc_pkg::NODE_IDX_W-1:0];
            tbl_req.wdata = '{lp: item.left_present, li: item.left_index,
                              rp: item.right_present, ri: item.right_index};
            node_total_nxt = node_total_r + 1'b1;
          end else begin
            bad_seen_nxt = 1'b1;
          end
          if (item.last_node) begin
            if (bad_seen_r ||
                node_total_r >= tbsc_pkg::NODE_CNT_W'(tbsc_pkg::MAX_NODES)) begin
              res_nxt        = '{strobe: 1'b1, valid_res: 1'b0, overflow: 1'b1};
              node_total_nxt = '0;
              bad_seen_nxt   = 1'b0;
            end else begin
              idx_nxt   = '0;
              fail_nxt  = 1'b0;
              roots_nxt = '0;
              state_nxt = tbsc_pkg::ST_PAR_RD;
            end
          end
        end
      end

      // parent count pass: fetch child pair of node idx
      tbsc_pkg::ST_PAR_RD: begin
        tbl_req.re    = 1'b1;
        tbl_req.raddr = idx_r[tbsc_pkg::NODE_IDX_W-1:0];
        state_nxt     = tbsc_pkg::ST_PAR_L;
      end

      tbsc_pkg::ST_PAR_L: begin
        entry_nxt = tbl_rdata;
        if (tbl_rdata.lp) begin
          if (tbsc_pkg::child_cmp(tbl_rdata.li) >= tbsc_pkg::CMP_W'(node_total_r)) begin
            fail_nxt    = 1'b1;
            idx_nxt     = '0;
            clr_lim_nxt = node_total_r;
            emit_nxt    = 1'b1;
            state_nxt   = tbsc_pkg::ST_CLR;
          end else begin
            cnt_req.re    = 1'b1;
            cnt_req.raddr = tbsc_pkg::child_addr(tbl_rdata.li);
            state_nxt     = tbsc_pkg::ST_PAR_LWR;
          end
        end else begin
          state_nxt = tbsc_pkg::ST_PAR_R;
        end
      end

      tbsc_pkg::ST_PAR_LWR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = tbsc_pkg::child_addr(entry_r.li);
        cnt_req.wdata = '{visited: cw.visited,
                          count: (cw.count == 2'd3) ? 2'd3 : cw.count + 2'd1};
        state_nxt     = tbsc_pkg::ST_PAR_R;
      end

      tbsc_pkg::ST_PAR_R: begin
        if (entry_r.rp) begin
          if (tbsc_pkg::child_cmp(entry_r.ri) >= tbsc_pkg::CMP_W'(node_total_r)) begin
            fail_nxt    = 1'b1;
            idx_nxt     = '0;
            clr_lim_nxt = node_total_r;
            emit_nxt    = 1'b1;
            state_nxt   = tbsc_pkg::ST_CLR;
          end else begin
            cnt_req.re    = 1'b1;
            cnt_req.raddr = tbsc_pkg::child_addr(entry_r.ri);
            state_nxt     = tbsc_pkg::ST_PAR_RWR;
          end
        end else if (idx_inc == node_total_r) begin
          idx_nxt   = '0;
          state_nxt = tbsc_pkg::ST_SCAN_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = tbsc_pkg::ST_PAR_RD;
        end
      end

      tbsc_pkg::ST_PAR_RWR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = tbsc_pkg::child_addr(entry_r.ri);
        cnt_req.wdata = '{visited: cw.visited,
                          count: (cw.count == 2'd3) ? 2'd3 : cw.count + 2'd1};
        if (idx_inc == node_total_r) begin
          idx_nxt   = '0;
          state_nxt = tbsc_pkg::ST_SCAN_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = tbsc_pkg::ST_PAR_RD;
        end
      end

      // root scan: no double parents, count parentless nodes
      tbsc_pkg::ST_SCAN_RD: begin
        cnt_req.re    = 1'b1;
        cnt_req.raddr = idx_r[tbsc_pkg::NODE_IDX_W-1:0];
        state_nxt     = tbsc_pkg::ST_SCAN_EV;
      end

      tbsc_pkg::ST_SCAN_EV: begin
        if (cw.count > 2'd1) begin
          fail_nxt    = 1'b1;
          idx_nxt     = '0;
          clr_lim_nxt = node_total_r;
          emit_nxt    = 1'b1;
          state_nxt   = tbsc_pkg::ST_CLR;
        end else begin
          if (cw.count == 2'd0) begin
            if (roots_v != 2'd2) begin
              roots_v = roots_v + 2'd1;
            end
            root_v = idx_r[tbsc_pkg::NODE_IDX_W-1:0];
          end
          roots_nxt = roots_v;
          root_nxt  = root_v;
          if (idx_inc == node_total_r) begin
            if (roots_v == 2'd1) begin
              // seed the stack with the root
              stk_req.we    = 1'b1;
              stk_req.waddr = '0;
              stk_req.wdata = root_v;
              depth_nxt     = tbsc_pkg::NODE_CNT_W'(1);
              reached_nxt   = '0;
              state_nxt     = tbsc_pkg::ST_WALK_POP;
            end else begin
              fail_nxt    = 1'b1;
              idx_nxt     = '0;
              clr_lim_nxt = node_total_r;
              emit_nxt    = 1'b1;
              state_nxt   = tbsc_pkg::ST_CLR;
            end
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = tbsc_pkg::ST_SCAN_RD;
          end
        end
      end

      // depth-first walk: pop, or finish when the stack is empty
      tbsc_pkg::ST_WALK_POP: begin
        if (depth_r == '0) begin
          fail_nxt    = (reached_r != node_total_r);
          idx_nxt     = '0;
          clr_lim_nxt = node_total_r;
          emit_nxt    = 1'b1;
          state_nxt   = tbsc_pkg::ST_CLR;
        end else begin
          stk_req.re    = 1'b1;
          stk_req.raddr = depth_nxt[tbsc_pkg::NODE_IDX_W-1:0];
          depth_nxt     = depth_r - 1'b1;
          stk_req.raddr = depth_nxt[tbsc_pkg::NODE_IDX_W-1:0];
          state_nxt     = tbsc_pkg::ST_WALK_RD;
        end
      end

      tbsc_pkg::ST_WALK_RD: begin
        node_nxt = stk_rdata;
        if (tbsc_pkg::NODE_CNT_W'(stk_rdata) >= node_total_r) begin
          fail_nxt    = 1'b1;
          idx_nxt     = '0;
          clr_lim_nxt = node_total_r;
          emit_nxt    = 1'b1;
          state_nxt   = tbsc_pkg::ST_CLR;
        end else begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = stk_rdata;
          cnt_req.re    = 1'b1;
          cnt_req.raddr = stk_rdata;
          state_nxt     = tbsc_pkg::ST_WALK_VIS;
        end
      end

      // mark visited, push left child
      tbsc_pkg::ST_WALK_VIS: begin
        entry_nxt = tbl_rdata;
        if (cw.visited || (tbl_rdata.lp && full)) begin
          fail_nxt    = 1'b1;
          idx_nxt     = '0;
          clr_lim_nxt = node_total_r;
          emit_nxt    = 1'b1;
          state_nxt   = tbsc_pkg::ST_CLR;
        end else begin
          cnt_req.we    = 1'b1;
          cnt_req.waddr = node_r;
          cnt_req.wdata = '{visited: 1'b1, count: cw.count};
          reached_nxt   = reached_r + 1'b1;
          if (tbl_rdata.lp) begin
            stk_req.we    = 1'b1;
            stk_req.waddr = depth_r[tbsc_pkg::NODE_IDX_W-1:0];
            stk_req.wdata = tbsc_pkg::child_addr(tbl_rdata.li);
            depth_nxt     = depth_r + 1'b1;
          end
          state_nxt = tbsc_pkg::ST_WALK_PUSH;
        end
      end

      // push right child
      tbsc_pkg::ST_WALK_PUSH: begin
        if (entry_r.rp && full) begin
          fail_nxt    = 1'b1;
          idx_nxt     = '0;
          clr_lim_nxt = node_total_r;
          emit_nxt    = 1'b1;
          state_nxt   = tbsc_pkg::ST_CLR;
        end else begin
          if (entry_r.rp) begin
            stk_req.we    = 1'b1;
            stk_req.waddr = depth_r[tbsc_pkg::NODE_IDX_W-1:0];
            stk_req.wdata = tbsc_pkg::child_addr(entry_r.ri);
            depth_nxt     = depth_r + 1'b1;
          end
          state_nxt = tbsc_pkg::ST_WALK_POP;
        end
      end

      // clear counts and visited flags of the first clr_lim entries, then report if due and go idle
      tbsc_pkg::ST_CLR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = idx_r[tbsc_pkg::NODE_IDX_W-1:0];
        cnt_req.wdata = '0;
        idx_nxt       = idx_inc;
        if (idx_inc == clr_lim_r) begin
          if (emit_r) begin
            res_nxt = '{strobe: 1'b1, valid_res: !fail_r, overflow: 1'b0};
          end
          emit_nxt       = 1'b0;
          node_total_nxt = '0;
          bad_seen_nxt   = 1'b0;
          idx_nxt        = '0;
          state_nxt      = tbsc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tbsc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != tbsc_pkg::ST_IDLE);
  assign res  = res_r;

endmodule

/* sv/binary_tree_shape_checker_top.sv */
// Binary tree shape checker, top level; uses tbsc_pkg, tbsc_seq and tbsc_ram.
// Node beats load at one per cycle while busy is low. The beat with last_node set starts a
// check that runs the parent count, root scan, depth-first walk and clear passes, ending
// early when a defect is found; the strobe follows the last clear cycle.
// Overflowed sets report in the cycle after the last beat; results cannot be held off.
// Synchronous reset; after reset all MAX_NODES (1024) count map entries are cleared while busy.
module binary_tree_shape_checker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_left_present,
  input  logic [tbsc_pkg::FIELD_IDX_W-1:0] in_left_index,
  input  logic                        in_right_present,
  input  logic [tbsc_pkg::FIELD_IDX_W-1:0] in_right_index,
  input  logic                        in_last_node,
  output logic                        out_strobe,
  output logic                        out_valid_res,
  output logic                        out_overflow
);

  tbsc_pkg::item_t      item;
  tbsc_pkg::res_t       res;
  tbsc_pkg::tbl_req_t   tbl_req;
  tbsc_pkg::tbl_entry_t tbl_rdata;
  tbsc_pkg::cnt_req_t   cnt_req;
  tbsc_pkg::cnt_word_t  cnt_rdata;
  tbsc_pkg::stk_req_t   stk_req;
  tbsc_pkg::node_idx_t  stk_rdata;

  // pack the input beat
  assign item = '{left_present: in_left_present, left_index: in_left_index,
                  right_present: in_right_present, right_index: in_right_index,
                  last_node: in_last_node};

  tbsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .res       (res),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata),
    .cnt_req   (cnt_req),
    .cnt_rdata (cnt_rdata),
    .stk_req   (stk_req),
    .stk_rdata (stk_rdata)
  );

  // child table: present bit and index for both children
  tbsc_ram #(
    .WIDTH ($bits(tbsc_pkg::tbl_entry_t)),
    .DEPTH (tbsc_pkg::MAX_NODES)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_req.we),
    .waddr (tbl_req.waddr),
    .wdata (tbl_req.wdata),
    .re    (tbl_req.re),
    .raddr (tbl_req.raddr),
    .rdata (tbl_rdata)
  );

  // parent count and visited flag
  tbsc_ram #(
    .WIDTH ($bits(tbsc_pkg::cnt_word_t)),
    .DEPTH (tbsc_pkg::MAX_NODES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_req.we),
    .waddr (cnt_req.waddr),
    .wdata (cnt_req.wdata),
    .re    (cnt_req.re),
    .raddr (cnt_req.raddr),
    .rdata (cnt_rdata)
  );

  // walk stack
  tbsc_ram #(
    .WIDTH (tbsc_pkg::NODE_IDX_W),
    .DEPTH (tbsc_pkg::MAX_NODES)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .re    (stk_req.re),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

  assign out_strobe    = res.strobe;
  assign out_valid_res = res.valid_res;
  assign out_overflow  = res.overflow;

endmodule
